/* hdl/cthr_pkg.sv */
// Package for the collision threat classifier: class codes, register
// indexes, sensitivity level and threshold functions, eval result struct.
// No dependencies.
`default_nettype none

package cthr_pkg;

    localparam int MAX_INTRUDERS_DEF = 64;
    localparam int IDX_W             = 6;
    localparam int CFG_W             = 16;
    localparam int CFG_ADDR_W        = 1;

    localparam logic [CFG_ADDR_W-1:0] REG_PROX_RANGE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PROX_ALT   = 1'b1;

    localparam logic [CFG_W-1:0] PROX_RANGE_RST = 16'd600;
    localparam logic [CFG_W-1:0] PROX_ALT_RST   = 16'd1200;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_PROX = 2'd1,
        CLS_TA   = 2'd2,
        CLS_RA   = 2'd3
    } t_class;

    // per-slot stored entry
    typedef struct packed {
        logic   ta_mode;
        t_class cls;
    } t_entry;

    typedef struct packed {
        t_entry     entry;
        logic       release_ra;
        logic [2:0] level;
    } t_eval;

    function automatic logic [2:0] level_of(input logic signed [16:0] alt);
        logic [2:0] lvl;
        if (alt < 17'sd1000)       lvl = 3'd2;
        else if (alt < 17'sd2350)  lvl = 3'd3;
        else if (alt < 17'sd5000)  lvl = 3'd4;
        else if (alt < 17'sd10000) lvl = 3'd5;
        else if (alt < 17'sd20000) lvl = 3'd6;
        else if (alt < 17'sd42000) lvl = 3'd7;
        else                       lvl = 3'd0;
        return lvl;
    endfunction

    // tau threshold already scaled by 16
    function automatic logic [9:0] tau16_of(input logic ta, input logic [2:0] lvl);
        logic [9:0] t;
        if (ta) begin
            case (lvl)
                3'd3:    t = 10'd240;
                3'd4:    t = 10'd320;
                3'd5:    t = 10'd400;
                3'd6:    t = 10'd480;
                3'd7:    t = 10'd560;
                default: t = 10'd0;
            endcase
        end else begin
            case (lvl)
                3'd2:    t = 10'd320;
                3'd3:    t = 10'd400;
                3'd4:    t = 10'd480;
                3'd5:    t = 10'd640;
                3'd6:    t = 10'd720;
                3'd7:    t = 10'd928;
                default: t = 10'd0;
            endcase
        end
        return t;
    endfunction

    function automatic logic [9:0] zthr_of(input logic ta, input logic [2:0] lvl);
        logic [9:0] z;
        if (ta) begin
            case (lvl)
                3'd3, 3'd4, 3'd5, 3'd6: z = 10'd600;
                3'd7:                   z = 10'd700;
                default:                z = 10'd0;
            endcase
        end else begin
            case (lvl)
                3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7: z = 10'd850;
                default:                            z = 10'd0;
            endcase
        end
        return z;
    endfunction

    function automatic logic passes(input logic ta, input logic [2:0] lvl,
                                    input logic signed [15:0] mtau,
                                    input logic [15:0] sep);
        logic signed [15:0] t;
        logic [15:0]        z;
        t = $signed({6'b0, tau16_of(ta, lvl)});
        z = {6'b0, zthr_of(ta, lvl)};
        return (mtau < t) && (sep < z);
    endfunction

endpackage

`default_nettype wire

/* hdl/cthr_eval.sv */
// Threat evaluation for one intruder request: proximity test, threshold
// tests and escalation from the stored entry. Uses cthr_pkg.
`default_nettype none

module cthr_eval
    import cthr_pkg::*;
(
    input  wire logic signed [16:0] i_own_altitude,
    input  wire logic [15:0]        i_slant_range,
    input  wire logic [15:0]        i_alt_separation,
    input  wire logic signed [11:0] i_closing_speed,
    input  wire logic signed [15:0] i_mod_tau,
    input  wire t_entry             i_prev,
    input  wire logic [CFG_W-1:0]   i_prox_range,
    input  wire logic [CFG_W-1:0]   i_prox_alt,
    output t_eval                   o_eval
);

    logic [2:0] lvl;
    logic       prox;
    logic       pass_cur;
    logic       pass_ta;
    logic       escalate;

    always_comb begin
        lvl      = level_of(i_own_altitude);
        prox     = (i_slant_range < i_prox_range) && (i_alt_separation < i_prox_alt);
        pass_cur = passes(i_prev.ta_mode, lvl, i_mod_tau, i_alt_separation);
        pass_ta  = passes(1'b1, lvl, i_mod_tau, i_alt_separation);
        escalate = (i_closing_speed > 12'sd0)
                   && ((i_prev.cls == CLS_TA) || (i_prev.cls == CLS_RA) || pass_cur);

        o_eval.level         = lvl;
        o_eval.release_ra    = 1'b1;
        o_eval.entry.ta_mode = i_prev.ta_mode;
        o_eval.entry.cls     = CLS_NONE;
        if (prox) begin
            if (escalate) begin
                o_eval.entry.ta_mode = 1'b1;
                if ((i_prev.cls == CLS_RA) || pass_ta) begin
                    o_eval.entry.cls  = CLS_RA;
                    o_eval.release_ra = 1'b0;
                end else begin
                    o_eval.entry.cls = CLS_TA;
                end
            end else begin
                o_eval.entry.cls     = CLS_PROX;
                o_eval.entry.ta_mode = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/collision_threat_classifier.sv */
// Collision threat classifier top level: slot memory, forwarding, advisory
// ownership and output register. Uses cthr_pkg and cthr_eval.
//
// channel   direction  fields (low bit first)
// s_axis    in         intruder_index, own_altitude, slant_range,
//                      alt_separation, closing_speed, mod_tau
// m_axis    out        threat_class, advisory_active, advisory_owner,
//                      advisory_cleared, sensitivity_level
// cfg       in         0 proximity_range, 1 proximity_alt
//
// One request per cycle unless the output stalls; memory read and request are
// registered at accept, then evaluated and written into the output register.
// Back-to-back requests to the same slot are forwarded from the write port.
// Reset clears slot valid bits at once; no clearing pass.
// Output stall holds the eval stage; input ready drops only when both are full.
`default_nettype none

module collision_threat_classifier
    import cthr_pkg::*;
#(
    parameter int MAX_INTRUDERS = MAX_INTRUDERS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // intruder_index[5:0], own_altitude[22:6], slant_range[38:23],
    // alt_separation[54:39], closing_speed[66:55], mod_tau[82:67]
    input  wire logic [87:0]           i_s_tdata,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // threat_class[1:0], advisory_active[2], advisory_owner[8:3],
    // advisory_cleared[9], sensitivity_level[12:10]
    output logic [15:0]                o_m_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata
);

    localparam int DEPTH = (MAX_INTRUDERS < 64) ? MAX_INTRUDERS : 64;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0] r_prox_range;
    logic [CFG_W-1:0] r_prox_alt;

    t_entry            mem [DEPTH];
    logic [DEPTH-1:0]  r_vbit;
    t_entry            r_rd_data;
    logic              r_rd_vbit;

    logic              r_s1_vld;
    logic              r_s1_ok;
    logic [IDX_W-1:0]  r_s1_idx;
    logic signed [16:0] r_s1_alt;
    logic [15:0]       r_s1_range;
    logic [15:0]       r_s1_sep;
    logic signed [11:0] r_s1_closing;
    logic signed [15:0] r_s1_mtau;

    logic              r_fwd_vld;
    logic [AW-1:0]     r_fwd_addr;
    t_entry            r_fwd_data;

    logic              r_held;
    logic [IDX_W-1:0]  r_owner;
    logic              n_held;
    logic [IDX_W-1:0]  n_owner;
    logic              cleared;

    logic              r_out_vld;
    logic [15:0]       r_out_data;

    logic              in_acc;
    logic              s1_go;
    logic              wr_en;
    logic [IDX_W-1:0]  in_idx;
    logic              in_ok;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     s1_addr;
    t_entry            prev;
    t_eval             ev;

    assign in_idx  = i_s_tdata[5:0];
    assign in_ok   = 32'(in_idx) < MAX_INTRUDERS;
    assign rd_addr = in_idx[AW-1:0];
    assign s1_addr = r_s1_idx[AW-1:0];

    assign s1_go      = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_go;
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign wr_en      = s1_go && r_s1_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prox_range <= PROX_RANGE_RST;
            r_prox_alt   <= PROX_ALT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_PROX_RANGE: r_prox_range <= i_cfg_wdata;
                REG_PROX_ALT:   r_prox_alt   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // slot memory: read on accept, write back from eval stage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[s1_addr] <= ev.entry;
        end
        if (in_acc && in_ok) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit    <= '0;
            r_rd_vbit <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vbit[s1_addr] <= 1'b1;
            end
            if (in_acc) begin
                r_rd_vbit <= in_ok && r_vbit[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld  <= 1'b1;
                r_fwd_vld <= wr_en;
            end else if (s1_go) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_ok      <= in_ok;
            r_s1_idx     <= in_idx;
            r_s1_alt     <= $signed(i_s_tdata[22:6]);
            r_s1_range   <= i_s_tdata[38:23];
            r_s1_sep     <= i_s_tdata[54:39];
            r_s1_closing <= $signed(i_s_tdata[66:55]);
            r_s1_mtau    <= $signed(i_s_tdata[82:67]);
            r_fwd_addr   <= s1_addr;
            r_fwd_data   <= ev.entry;
        end
    end

    always_comb begin
        prev = '{ta_mode: 1'b0, cls: CLS_NONE};
        if (r_s1_ok) begin
            if (r_fwd_vld && (r_fwd_addr == s1_addr)) begin
                prev = r_fwd_data;
            end else if (r_rd_vbit) begin
                prev = r_rd_data;
            end
        end
    end

    cthr_eval u_eval (
        .i_own_altitude   (r_s1_alt),
        .i_slant_range    (r_s1_range),
        .i_alt_separation (r_s1_sep),
        .i_closing_speed  (r_s1_closing),
        .i_mod_tau        (r_s1_mtau),
        .i_prev           (prev),
        .i_prox_range     (r_prox_range),
        .i_prox_alt       (r_prox_alt),
        .o_eval           (ev)
    );

    always_comb begin
        n_held  = r_held;
        n_owner = r_owner;
        cleared = 1'b0;
        if ((ev.entry.cls == CLS_RA) && !r_held) begin
            n_held  = 1'b1;
            n_owner = r_s1_idx;
        end
        if (ev.release_ra && r_held && (r_owner == r_s1_idx)) begin
            n_held  = 1'b0;
            cleared = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= 1'b0;
            r_owner   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_go) begin
                r_held    <= n_held;
                r_owner   <= n_owner;
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= {3'b0, ev.level, cleared, (n_held ? n_owner : {IDX_W{1'b0}}),
                           n_held, ev.entry.cls};
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_clr_not_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_data[9] |-> !r_out_data[2])
        else $error("advisory cleared and active in one result");

    a_held_fall_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_held) |-> $past(s1_go))
        else $error("advisory released without an evaluated request");

    a_go_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_vld)
        else $error("evaluated request did not reach the output register");

    a_ready_low_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_s1_vld && r_out_vld && !i_m_tready)
        else $error("input stalled while pipeline has room");
`endif

endmodule

`default_nettype wire
